>>> rtl/iirlp_pkg.sv
// Types and constants shared by the third-order IIR low-pass filter.
// Used by the channel interfaces, the datapath and the top level.
// No dependencies.

package iirlp_pkg;

	localparam int CH_W     = 2;
	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 48;
	localparam int HIST_W   = 48;
	localparam int CIDX_W   = 3;
	localparam int NUM_COEF = 7;
	localparam int NUM_TAPS = 3;
	localparam int HALF_W   = 24;

	// Sum widths: one feedforward term is 72 bits, one feedback term 96 bits.
	localparam int FF_TERM_W = SAMPLE_W + COEF_W;
	localparam int FB_TERM_W = HIST_W + COEF_W;
	localparam int FF_SUM_W  = FF_TERM_W + 2;
	localparam int FB_SUM_W  = FB_TERM_W + 2;
	localparam int ACC_W     = 100;
	localparam int YWIDE_W   = ACC_W - 44;

	typedef logic [CH_W-1:0]            chan_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [HIST_W-1:0]   hist_t;
	typedef logic [CIDX_W-1:0]          cfg_idx_t;

	// Register indexes of the coefficient file.
	localparam int COEF_B0 = 0;
	localparam int COEF_A1 = 4;

	localparam coef_t COEF_RESET [NUM_COEF] = '{
		48'sd27567137621,
		48'sd82701412863,
		48'sd82701412863,
		48'sd27567137621,
		-48'sd43955982852093,
		48'sd37211944133403,
		-48'sd10627610233637
	};

	localparam logic signed [ACC_W-1:0] ROUND_Y = 100'sh80000000000;
	localparam logic signed [HIST_W:0]  ROUND_Q = 49'sh800000;

	localparam hist_t   HIST_MAX   = 48'sh7FFFFFFFFFFF;
	localparam hist_t   HIST_MIN   = 48'sh800000000000;
	localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
	localparam sample_t SAMPLE_MIN = 24'sh800000;

	// Load enables of the arithmetic pipeline registers.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

>>> rtl/iirlp_if.sv
// Valid/ready channel interfaces of the IIR low-pass filter: sample requests,
// filtered results and coefficient writes. Depends on iirlp_pkg.

interface iirlp_in_if;
	logic                valid;
	logic                ready;
	iirlp_pkg::chan_t    channel;
	iirlp_pkg::sample_t  sample_in;

	modport source (output valid, output channel, output sample_in, input ready);
	modport sink (input valid, input channel, input sample_in, output ready);
endinterface

interface iirlp_out_if;
	logic                valid;
	logic                ready;
	iirlp_pkg::chan_t    channel_out;
	iirlp_pkg::sample_t  sample_out;
	logic                saturated;

	modport source (output valid, output channel_out, output sample_out, output saturated,
		input ready);
	modport sink (input valid, input channel_out, input sample_out, input saturated,
		output ready);
endinterface

interface iirlp_cfg_if;
	logic                 valid;
	logic                 ready;
	iirlp_pkg::cfg_idx_t  index;
	iirlp_pkg::coef_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/iirlp_datapath.sv
// Multiply-accumulate datapath of the IIR low-pass filter: partial products,
// term assembly, sums, rounding and saturation. Depends on iirlp_pkg.

module iirlp_datapath (
	input  logic                   clk,
	input  iirlp_pkg::stage_en_t   en,
	input  iirlp_pkg::sample_t     x,
	input  iirlp_pkg::sample_t     xh [iirlp_pkg::NUM_TAPS],
	input  iirlp_pkg::hist_t       yh [iirlp_pkg::NUM_TAPS],
	input  iirlp_pkg::coef_t       coef [iirlp_pkg::NUM_COEF],
	output iirlp_pkg::hist_t       y_hist,
	output iirlp_pkg::sample_t     sample_val,
	output logic                   sat
);
	import iirlp_pkg::*;

	localparam int NUM_FF = NUM_TAPS + 1;

	sample_t xin [NUM_FF];

	// Each 48-bit operand is split into a signed upper and an unsigned lower half.
	logic signed [HIST_W-1:0]  ffh_s2  [NUM_FF];
	logic signed [HIST_W:0]    ffl_s2  [NUM_FF];
	logic signed [HIST_W-1:0]  fbhh_s2 [NUM_TAPS];
	logic signed [HIST_W:0]    fbhl_s2 [NUM_TAPS];
	logic signed [HIST_W:0]    fblh_s2 [NUM_TAPS];
	logic [HIST_W-1:0]         fbll_s2 [NUM_TAPS];

	logic signed [FF_TERM_W-1:0] ff_term_s3 [NUM_FF];
	logic signed [FB_TERM_W-1:0] fb_term_s3 [NUM_TAPS];

	logic signed [FF_SUM_W-1:0] ff_sum_s4;
	logic signed [FB_SUM_W-1:0] fb_sum_s4;

	logic signed [ACC_W-1:0]   acc;
	logic signed [YWIDE_W-1:0] ywide;
	logic                      sat_h;
	hist_t                     y_clip;
	logic signed [HIST_W:0]    q_round;
	logic signed [SAMPLE_W:0]  q_wide;
	logic                      sat_q;

	assign xin[0] = x;
	assign xin[1] = xh[0];
	assign xin[2] = xh[1];
	assign xin[3] = xh[2];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < NUM_FF; k++) begin
				ffh_s2[k] <= xin[k] * $signed(coef[COEF_B0 + k][COEF_W-1:HALF_W]);
				ffl_s2[k] <= xin[k] * $signed({1'b0, coef[COEF_B0 + k][HALF_W-1:0]});
			end
			for (int j = 0; j < NUM_TAPS; j++) begin
				fbhh_s2[j] <= $signed(yh[j][HIST_W-1:HALF_W])
					* $signed(coef[COEF_A1 + j][COEF_W-1:HALF_W]);
				fbhl_s2[j] <= $signed(yh[j][HIST_W-1:HALF_W])
					* $signed({1'b0, coef[COEF_A1 + j][HALF_W-1:0]});
				fblh_s2[j] <= $signed({1'b0, yh[j][HALF_W-1:0]})
					* $signed(coef[COEF_A1 + j][COEF_W-1:HALF_W]);
				fbll_s2[j] <= yh[j][HALF_W-1:0] * coef[COEF_A1 + j][HALF_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < NUM_FF; k++) begin
				ff_term_s3[k] <= $signed({ffh_s2[k], {HALF_W{1'b0}}})
					+ FF_TERM_W'(ffl_s2[k]);
			end
			for (int j = 0; j < NUM_TAPS; j++) begin
				fb_term_s3[j] <= $signed({fbhh_s2[j], {HIST_W{1'b0}}})
					+ $signed({{(HALF_W-1){fbhl_s2[j][HIST_W]}}, fbhl_s2[j], {HALF_W{1'b0}}})
					+ $signed({{(HALF_W-1){fblh_s2[j][HIST_W]}}, fblh_s2[j], {HALF_W{1'b0}}})
					+ $signed({{HIST_W{1'b0}}, fbll_s2[j]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			ff_sum_s4 <= FF_SUM_W'(ff_term_s3[0]) + FF_SUM_W'(ff_term_s3[1])
				+ FF_SUM_W'(ff_term_s3[2]) + FF_SUM_W'(ff_term_s3[3]);
			fb_sum_s4 <= FB_SUM_W'(fb_term_s3[0]) + FB_SUM_W'(fb_term_s3[1])
				+ FB_SUM_W'(fb_term_s3[2]);
		end
	end

	// Feedforward sum is Q.60 and is aligned to the Q.84 feedback sum.
	always_comb begin
		acc = $signed({{2{ff_sum_s4[FF_SUM_W-1]}}, ff_sum_s4, {HALF_W{1'b0}}})
			- ACC_W'(fb_sum_s4) + ROUND_Y;
		ywide = $signed(acc[ACC_W-1:ACC_W-YWIDE_W]);
		sat_h = !((&ywide[YWIDE_W-1:HIST_W-1]) || !(|ywide[YWIDE_W-1:HIST_W-1]));
		if (sat_h) begin
			y_clip = ywide[YWIDE_W-1] ? HIST_MIN : HIST_MAX;
		end else begin
			y_clip = ywide[HIST_W-1:0];
		end
		q_round = (HIST_W + 1)'(y_clip) + ROUND_Q;
		q_wide = $signed(q_round[HIST_W:HALF_W]);
		sat_q = q_wide[SAMPLE_W] != q_wide[SAMPLE_W-1];
		if (sat_q) begin
			sample_val = q_wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			sample_val = q_wide[SAMPLE_W-1:0];
		end
		y_hist = y_clip;
		sat = sat_h || sat_q;
	end

endmodule

>>> rtl/third_order_iir_lowpass.sv
// Third-order IIR low-pass filter, direct form I, over CHANNELS channels.
// Depends on iirlp_pkg, the channel interfaces and iirlp_datapath.

// Each request carries a channel number and a signed Q8.16 sample and yields
// one result: the filtered sample rounded to Q8.16 and saturated, the channel
// echoed, and a flag set when clipping occurred. Coefficients are seven Q4.44
// registers written through the configuration channel; output history is kept
// at Q8.40. The datapath is four stages deep (input register, partial products,
// term assembly, sums with rounding) plus the result register. Requests for
// different channels are taken one per cycle unless the results channel
// stalls; a request whose channel still has an earlier request in the three
// arithmetic stages waits until that one writes its output back, so a channel
// takes no new request before its last one is through, and a round-robin
// stream over four or more channels runs at full rate. Channel numbers not
// below CHANNELS are filtered with zero history and leave all state alone.

module third_order_iir_lowpass #(
	parameter int CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	iirlp_in_if.sink          samples,
	iirlp_out_if.source       results,
	iirlp_cfg_if.sink         cfg
);
	import iirlp_pkg::*;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	coef_t coef_q [NUM_COEF];

	sample_t x_hist_q [CHANNELS][NUM_TAPS];
	hist_t   y_hist_q [CHANNELS][NUM_TAPS];

	logic    valid_s1, valid_s2, valid_s3, valid_s4;
	chan_t   ch_s1, ch_s2, ch_s3, ch_s4;
	logic    chv_s2, chv_s3, chv_s4;
	sample_t x_s1;
	hist_t   yh0_s2, yh1_s2, yh0_s3, yh1_s3, yh0_s4, yh1_s4;

	logic    out_valid_q;
	chan_t   out_ch_q;
	sample_t out_sample_q;
	logic    out_sat_q;

	logic                          chv_s1;
	logic [CH_IDX_W+CH_W-1:0]      ch1_ext, ch4_ext;
	logic [CH_IDX_W-1:0]           idx_s1, idx_s4;
	sample_t                       xh [NUM_TAPS];
	hist_t                         yh [NUM_TAPS];
	logic                          hazard;
	logic                          out_free, rdy4, rdy3, rdy2, adv1, adv4;
	stage_en_t                     en;
	hist_t                         y_new;
	sample_t                       sample_new;
	logic                          sat_new;

	assign chv_s1  = 32'(ch_s1) < CHANNELS;
	assign ch1_ext = {{CH_IDX_W{1'b0}}, ch_s1};
	assign ch4_ext = {{CH_IDX_W{1'b0}}, ch_s4};
	assign idx_s1  = ch1_ext[CH_IDX_W-1:0];
	assign idx_s4  = ch4_ext[CH_IDX_W-1:0];

	always_comb begin
		for (int t = 0; t < NUM_TAPS; t++) begin
			xh[t] = chv_s1 ? x_hist_q[idx_s1][t] : '0;
			yh[t] = chv_s1 ? y_hist_q[idx_s1][t] : '0;
		end
	end

	// A request may not read its history while an earlier one of the same
	// channel has not yet written its output back.
	assign hazard = chv_s1 && ((valid_s2 && ch_s2 == ch_s1)
		|| (valid_s3 && ch_s3 == ch_s1) || (valid_s4 && ch_s4 == ch_s1));

	assign out_free = !out_valid_q || results.ready;
	assign rdy4     = !valid_s4 || out_free;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign adv1     = valid_s1 && !hazard && rdy2;
	assign adv4     = valid_s4 && out_free;
	assign en       = '{s2: rdy2, s3: rdy3, s4: rdy4};

	assign samples.ready = !valid_s1 || adv1;
	assign cfg.ready     = 1'b1;

	iirlp_datapath u_datapath (
		.clk        (clk),
		.en         (en),
		.x          (x_s1),
		.xh         (xh),
		.yh         (yh),
		.coef       (coef_q),
		.y_hist     (y_new),
		.sample_val (sample_new),
		.sat        (sat_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_COEF; r++) begin
				coef_q[r] <= COEF_RESET[r];
			end
		end else if (cfg.valid && 32'(cfg.index) < NUM_COEF) begin
			coef_q[cfg.index] <= cfg.data;
		end
	end

	// Control state of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (samples.ready) begin
				valid_s1 <= samples.valid;
			end
			if (rdy2) begin
				valid_s2 <= adv1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (out_free) begin
				out_valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready) begin
			ch_s1 <= samples.channel;
			x_s1  <= samples.sample_in;
		end
		if (rdy2) begin
			ch_s2  <= ch_s1;
			chv_s2 <= chv_s1;
			yh0_s2 <= yh[0];
			yh1_s2 <= yh[1];
		end
		if (rdy3) begin
			ch_s3  <= ch_s2;
			chv_s3 <= chv_s2;
			yh0_s3 <= yh0_s2;
			yh1_s3 <= yh1_s2;
		end
		if (rdy4) begin
			ch_s4  <= ch_s3;
			chv_s4 <= chv_s3;
			yh0_s4 <= yh0_s3;
			yh1_s4 <= yh1_s3;
		end
		if (out_free) begin
			out_ch_q     <= ch_s4;
			out_sample_q <= sample_new;
			out_sat_q    <= sat_new;
		end
	end

	// Input history shifts when a request leaves the input register; output
	// history shifts when its result is formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int t = 0; t < NUM_TAPS; t++) begin
					x_hist_q[c][t] <= '0;
					y_hist_q[c][t] <= '0;
				end
			end
		end else begin
			if (adv1 && chv_s1) begin
				x_hist_q[idx_s1][0] <= x_s1;
				x_hist_q[idx_s1][1] <= xh[0];
				x_hist_q[idx_s1][2] <= xh[1];
			end
			if (adv4 && chv_s4) begin
				y_hist_q[idx_s4][0] <= y_new;
				y_hist_q[idx_s4][1] <= yh0_s4;
				y_hist_q[idx_s4][2] <= yh1_s4;
			end
		end
	end

	assign results.valid       = out_valid_q;
	assign results.channel_out = out_ch_q;
	assign results.sample_out  = out_sample_q;
	assign results.saturated   = out_sat_q;

endmodule

>>> tb/sv/iirlp_checker.sv
`timescale 1ns / 100ps
// Result checker for the third-order IIR low-pass filter: watches the request,
// result and coefficient channels, predicts each result and compares in order.
// Depends on iirlp_pkg and the channel interfaces in iirlp_if.sv.

module iirlp_checker #(
	parameter int CHANNELS = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	iirlp_in_if   samples,
	iirlp_out_if  results,
	iirlp_cfg_if  cfg,
	output int    errors,
	output int    pending
);
	import iirlp_pkg::*;

	typedef struct packed {
		chan_t   ch;
		sample_t value;
		logic    clipped;
	} filt_out_t;

	coef_t     coefs [NUM_COEF];
	sample_t   x_hist [CHANNELS][NUM_TAPS];
	hist_t     y_hist [CHANNELS][NUM_TAPS];
	filt_out_t filtered_q [$];
	int        fail_count = 0;

	assign errors = fail_count;

	task automatic report_mismatch(string msg);
		fail_count++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	// One filter step for a request, including the history update.
	function automatic filt_out_t filter_sample(chan_t ch, sample_t x);
		sample_t             xh [NUM_TAPS];
		hist_t               yh [NUM_TAPS];
		logic signed [127:0] ff;
		logic signed [127:0] fb;
		logic signed [127:0] acc;
		logic signed [127:0] y_wide;
		logic signed [63:0]  y_long;
		logic signed [63:0]  q_wide;
		hist_t               y;
		filt_out_t           r;
		logic                known_ch;
		known_ch = (ch < CHANNELS);
		for (int i = 0; i < NUM_TAPS; i++) begin
			xh[i] = known_ch ? x_hist[ch][i] : '0;
			yh[i] = known_ch ? y_hist[ch][i] : '0;
		end
		r.clipped = 1'b0;
		ff = x * coefs[COEF_B0];
		fb = '0;
		for (int i = 0; i < NUM_TAPS; i++) begin
			ff += xh[i] * coefs[COEF_B0 + 1 + i];
			fb += yh[i] * coefs[COEF_A1 + i];
		end
		// Feedforward products are Q.60; bring them to the Q.84 of the feedback terms.
		acc = (ff <<< 24) - fb + (128'sd1 <<< 43);
		y_wide = acc >>> 44;
		if (y_wide > HIST_MAX) begin
			y = HIST_MAX;
			r.clipped = 1'b1;
		end else if (y_wide < HIST_MIN) begin
			y = HIST_MIN;
			r.clipped = 1'b1;
		end else begin
			y = y_wide[HIST_W-1:0];
		end
		y_long = y;
		q_wide = (y_long + 64'sd8388608) >>> 24;
		if (q_wide > SAMPLE_MAX) begin
			r.value = SAMPLE_MAX;
			r.clipped = 1'b1;
		end else if (q_wide < SAMPLE_MIN) begin
			r.value = SAMPLE_MIN;
			r.clipped = 1'b1;
		end else begin
			r.value = q_wide[SAMPLE_W-1:0];
		end
		if (known_ch) begin
			for (int i = NUM_TAPS - 1; i > 0; i--) begin
				x_hist[ch][i] = xh[i-1];
				y_hist[ch][i] = yh[i-1];
			end
			x_hist[ch][0] = x;
			y_hist[ch][0] = y;
		end
		r.ch = ch;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filt_out_t want;
		filt_out_t predicted;
		if (!arst_n) begin
			coefs = COEF_RESET;
			x_hist = '{default: '0};
			y_hist = '{default: '0};
			filtered_q.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready && cfg.index < NUM_COEF) begin
				coefs[cfg.index] = cfg.data;
			end
			if (samples.valid && samples.ready) begin
				predicted = filter_sample(samples.channel, samples.sample_in);
				filtered_q = {filtered_q, predicted};
			end
			if (results.valid && results.ready) begin
				if (filtered_q.size() == 0) begin
					report_mismatch($sformatf("result for channel %0d with no request waiting",
						results.channel_out));
				end else begin
					want = filtered_q.pop_front();
					if (results.channel_out !== want.ch) begin
						report_mismatch($sformatf("channel_out %0d, expected %0d",
							results.channel_out, want.ch));
					end
					if (results.sample_out !== want.value) begin
						report_mismatch($sformatf("sample_out %0d, expected %0d (channel %0d)",
							results.sample_out, want.value, want.ch));
					end
					if (results.saturated !== want.clipped) begin
						report_mismatch($sformatf("saturated %0b, expected %0b (channel %0d)",
							results.saturated, want.clipped, want.ch));
					end
				end
			end
			pending <= filtered_q.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the IIR low-pass filter testbench: clock, reset, request and
// coefficient stimulus, result back-pressure and the verdict.
// Depends on iirlp_pkg, iirlp_if.sv, third_order_iir_lowpass and iirlp_checker.

module testbench;
	import iirlp_pkg::*;

	localparam int       CHANNELS  = 4;
	localparam int       LIMIT     = 400000;
	localparam coef_t    COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t    COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
	localparam cfg_idx_t IDX_SPARE = cfg_idx_t'(NUM_COEF);

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	int      errors;
	int      pending;
	int      cycles = 0;
	bit      calm = 1'b0;
	int      hold_len = 0;
	int      gap_odds = 0;
	chan_t   last_ch = '0;
	sample_t last_x = '0;

	iirlp_in_if  samples_if ();
	iirlp_out_if results_if ();
	iirlp_cfg_if cfg_if ();

	third_order_iir_lowpass #(.CHANNELS(CHANNELS)) dut (
		.clk,
		.arst_n,
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	iirlp_checker #(.CHANNELS(CHANNELS)) filter_check (
		.clk,
		.arst_n,
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off whenever one is asked for.
	initial begin
		results_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				results_if.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				results_if.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				results_if.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic send_sample(chan_t ch, sample_t x);
		if (gap_odds != 0 && !calm && $urandom_range(1, gap_odds) == 1) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		samples_if.valid     <= 1'b1;
		samples_if.channel   <= ch;
		samples_if.sample_in <= x;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		last_ch = ch;
		last_x = x;
	endtask

	// Stop requesting and wait until every result has come back.
	task automatic drain();
		samples_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_coef(cfg_idx_t idx, coef_t value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
	endtask

	task automatic load_coefs(coef_t set [NUM_COEF]);
		drain();
		for (int i = COEF_B0; i < NUM_COEF; i++) begin
			write_coef(cfg_idx_t'(i), set[i]);
		end
		// A write beyond the last register must leave the coefficients alone.
		write_coef(IDX_SPARE, coef_t'({$urandom, $urandom}));
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_phase(int n_items, int odds);
		chan_t   ch;
		sample_t x;
		gap_odds = odds;
		repeat (n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: ch = last_ch;
				4, 5, 6: ch = last_ch + 1'b1;
				default: ch = chan_t'($urandom);
			endcase
			// Slowly moving signals, with extremes and full-range noise mixed in.
			case ($urandom_range(0, 9))
				0: x = SAMPLE_MAX;
				1: x = SAMPLE_MIN;
				2: x = $urandom_range(0, 1) ? sample_t'(0) : sample_t'(-1);
				3, 4, 5: x = last_x + sample_t'($urandom_range(0, 8191)) - sample_t'(4096);
				default: x = sample_t'($urandom);
			endcase
			send_sample(ch, x);
		end
	endtask

	initial begin
		coef_t set [NUM_COEF];
		samples_if.valid     <= 1'b0;
		samples_if.channel   <= '0;
		samples_if.sample_in <= '0;
		cfg_if.valid         <= 1'b0;
		cfg_if.index         <= '0;
		cfg_if.data          <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: steps, extremes and alternation on the reset coefficients.
		send_sample(2'd0, SAMPLE_MAX);
		send_sample(2'd0, SAMPLE_MAX);
		send_sample(2'd0, SAMPLE_MAX);
		send_sample(2'd0, SAMPLE_MAX);
		send_sample(2'd1, SAMPLE_MIN);
		send_sample(2'd1, sample_t'(1));
		send_sample(2'd1, sample_t'(-1));
		send_sample(2'd2, sample_t'(0));
		send_sample(2'd3, SAMPLE_MAX);
		send_sample(2'd3, SAMPLE_MIN);
		send_sample(2'd3, SAMPLE_MAX);
		send_sample(2'd0, SAMPLE_MIN);
		send_sample(2'd2, sample_t'(0));
		send_sample(2'd0, sample_t'(0));

		// Large gain with runaway feedback drives the history into saturation.
		set = '{default: '0};
		set[COEF_B0] = COEF_MAX;
		set[COEF_A1] = COEF_MIN;
		load_coefs(set);
		send_sample(2'd0, SAMPLE_MAX);
		send_sample(2'd0, SAMPLE_MAX);
		send_sample(2'd1, SAMPLE_MIN);
		send_sample(2'd1, SAMPLE_MIN);
		send_sample(2'd2, sample_t'(1000));
		send_sample(2'd0, sample_t'(0));

		set = COEF_RESET;
		load_coefs(set);
		run_phase(90, 4);
		drain();
		run_phase(90, 0);

		set = '{default: COEF_MAX};
		load_coefs(set);
		run_phase(150, 2);

		set = '{default: COEF_MIN};
		load_coefs(set);
		run_phase(150, 8);

		set = '{default: '0};
		load_coefs(set);
		hold_len = 60;
		run_phase(100, 4);

		for (int i = COEF_B0; i < NUM_COEF; i++) begin
			set[i] = COEF_RESET[i] + $signed($urandom_range(0, 1 << 24)) - (1 << 23);
		end
		load_coefs(set);
		hold_len = 80;
		run_phase(250, 3);

		for (int i = COEF_B0; i < NUM_COEF; i++) begin
			set[i] = coef_t'({$urandom, $urandom});
		end
		load_coefs(set);
		run_phase(150, 4);

		set = COEF_RESET;
		load_coefs(set);
		calm = 1'b1;
		run_phase(180, 0);

		drain();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
